// File: rtl/core/llex_pkg.sv
// shared types and constants for the lisp token lexer
`timescale 1ns / 1ps

package llex_pkg;

    localparam int POS_BITS = 16;
    localparam int OFF_W    = 16;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    typedef logic [POS_BITS-1:0] t_pos;
    typedef logic [OFF_W-1:0]    t_off;

    typedef enum logic [3:0] {
        K_EOF        = 4'd0,
        K_LEFT       = 4'd1,
        K_RIGHT      = 4'd2,
        K_DOT        = 4'd3,
        K_PATH       = 4'd4,
        K_QLEFT      = 4'd5,
        K_QSYM       = 4'd6,
        K_STRING     = 4'd7,
        K_INT        = 4'd8,
        K_SYMBOL     = 4'd9,
        K_ERROR      = 4'd10
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_off  start_res;
        t_off  stop;
        logic  last;
    } t_res;

endpackage

// File: rtl/core/llex_core.sv
// lexer state registers and single-pass character decode
`timescale 1ns / 1ps

module llex_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic [7:0]     i_ch,
    output llex_pkg::t_res o_res0,
    output llex_pkg::t_res o_res1,
    output logic [1:0]     o_cnt
);
    import llex_pkg::*;

    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_NL     = 8'h0a;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_QUOTE  = 8'h27;
    localparam logic [7:0] C_LPAR   = 8'h28;
    localparam logic [7:0] C_RPAR   = 8'h29;
    localparam logic [7:0] C_DOT    = 8'h2e;
    localparam logic [7:0] C_SLASH  = 8'h2f;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_NINE   = 8'h39;
    localparam logic [7:0] C_SEMI   = 8'h3b;
    localparam logic [7:0] C_TILDE  = 8'h7e;
    localparam t_pos       POS_MAX  = '1;

    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_DOT, M_PATH, M_QUOTE,
        M_QSYM, M_STRING, M_INT, M_SYMBOL, M_ERROR
    } t_mode;

    typedef struct packed {
        logic  hit;
        t_res  res;
        t_mode mode;
        logic  set_ts;
    } t_idle;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= C_ZERO) && (c <= C_NINE);
    endfunction

    function automatic logic is_sym(input logic [7:0] c);
        logic excl;
        excl = (c == C_DQUOTE) || (c == C_QUOTE) || (c == C_DOT) ||
               (c == C_LPAR) || (c == C_RPAR);
        return !excl && (c > C_SPACE) && (c <= C_TILDE);
    endfunction

    function automatic t_res mk(input t_kind k, input t_pos s, input t_pos e);
        t_res r;
        r.kind      = k;
        r.start_res = OFF_W'(s);
        r.stop      = OFF_W'(e);
        r.last      = 1'b0;
        return r;
    endfunction

    // decode of a character seen in idle mode
    function automatic t_idle lex_idle(input logic [7:0] c, input t_pos p);
        t_idle d;
        d.hit    = 1'b0;
        d.res    = mk(K_ERROR, p, p);
        d.mode   = M_IDLE;
        d.set_ts = 1'b1;
        if ((c == C_SPACE) || (c == C_NL)) begin
            d.set_ts = 1'b0;
        end else if (c == C_SEMI) begin
            d.mode   = M_COMMENT;
            d.set_ts = 1'b0;
        end else if (c == C_LPAR) begin
            d.hit    = 1'b1;
            d.res    = mk(K_LEFT, p, p + t_pos'(1));
            d.set_ts = 1'b0;
        end else if (c == C_RPAR) begin
            d.hit    = 1'b1;
            d.res    = mk(K_RIGHT, p, p + t_pos'(1));
            d.set_ts = 1'b0;
        end else if (c == C_DOT) begin
            d.mode = M_DOT;
        end else if (c == C_QUOTE) begin
            d.mode = M_QUOTE;
        end else if (c == C_DQUOTE) begin
            d.mode = M_STRING;
        end else if (is_dig(c)) begin
            d.mode = M_INT;
        end else if (is_sym(c)) begin
            d.mode = M_SYMBOL;
        end else begin
            d.hit  = 1'b1;
            d.mode = M_ERROR;
        end
        return d;
    endfunction

    t_mode r_mode, n_mode;
    t_pos  r_ts, n_ts;
    t_pos  r_pos, n_pos;

    t_idle idl;
    t_res  e0, e1;
    logic  v0, v1;
    logic  use_idle;
    t_pos  p, ts;

    assign p   = r_pos;
    assign ts  = r_ts;
    assign idl = lex_idle(i_ch, p);

    always_comb begin
        n_mode   = r_mode;
        n_ts     = r_ts;
        n_pos    = r_pos;
        e0       = mk(K_EOF, p, p);
        e1       = mk(K_EOF, p, p);
        v0       = 1'b0;
        v1       = 1'b0;
        use_idle = 1'b0;
        if (i_ch == C_NUL) begin
            // flush open token, then eof, then back to the start of text
            v0 = 1'b1;
            unique case (r_mode) inside
                M_DOT:               e0 = mk(K_DOT, ts, ts + t_pos'(1));
                M_PATH:              e0 = mk(K_PATH, ts, p);
                M_QSYM:              e0 = mk(K_QSYM, ts, p);
                M_INT:               e0 = mk(K_INT, ts, p);
                M_SYMBOL:            e0 = mk(K_SYMBOL, ts, p);
                M_QUOTE, M_STRING:   e0 = mk(K_ERROR, ts, p);
                default:             v0 = 1'b0;
            endcase
            v1     = 1'b1;
            e1     = mk(K_EOF, p, p);
            n_mode = M_IDLE;
            n_ts   = '0;
            n_pos  = '0;
        end else if (r_mode == M_ERROR) begin
            if (p != POS_MAX) begin
                n_pos = p + t_pos'(1);
            end
        end else if (p == POS_MAX) begin
            v0     = 1'b1;
            e0     = mk(K_ERROR, (r_mode == M_IDLE || r_mode == M_COMMENT) ? p : ts, p);
            n_mode = M_ERROR;
        end else begin
            n_pos = p + t_pos'(1);
            unique case (r_mode) inside
                M_COMMENT: begin
                    if (i_ch == C_NL) n_mode = M_IDLE;
                end
                M_DOT: begin
                    if (i_ch == C_SLASH) begin
                        n_mode = M_PATH;
                    end else begin
                        v0       = 1'b1;
                        e0       = mk(K_DOT, ts, ts + t_pos'(1));
                        use_idle = 1'b1;
                    end
                end
                M_PATH: begin
                    if (!(is_sym(i_ch) || (i_ch == C_DOT))) begin
                        v0       = 1'b1;
                        e0       = mk(K_PATH, ts, p);
                        use_idle = 1'b1;
                    end
                end
                M_QUOTE: begin
                    if (i_ch == C_LPAR) begin
                        v0     = 1'b1;
                        e0     = mk(K_QLEFT, ts, p + t_pos'(1));
                        n_mode = M_IDLE;
                    end else if (is_sym(i_ch) && !is_dig(i_ch)) begin
                        n_ts   = p;
                        n_mode = M_QSYM;
                    end else begin
                        v0     = 1'b1;
                        e0     = mk(K_ERROR, ts, p);
                        n_mode = M_ERROR;
                    end
                end
                M_QSYM, M_SYMBOL: begin
                    if (!is_sym(i_ch)) begin
                        v0       = 1'b1;
                        e0       = mk((r_mode == M_QSYM) ? K_QSYM : K_SYMBOL, ts, p);
                        use_idle = 1'b1;
                    end
                end
                M_INT: begin
                    if (!is_dig(i_ch)) begin
                        v0       = 1'b1;
                        e0       = mk(K_INT, ts, p);
                        use_idle = 1'b1;
                    end
                end
                M_STRING: begin
                    if (i_ch == C_DQUOTE) begin
                        v0     = 1'b1;
                        e0     = mk(K_STRING, ts, p + t_pos'(1));
                        n_mode = M_IDLE;
                    end
                end
                default: use_idle = 1'b1;
            endcase
            // terminating character is lexed again from idle
            if (use_idle) begin
                v1     = idl.hit;
                e1     = idl.res;
                n_mode = idl.mode;
                if (idl.set_ts) n_ts = p;
            end
        end
    end

    always_comb begin
        o_res0 = v0 ? e0 : e1;
        o_res1 = e1;
        o_cnt  = {1'b0, v0} + {1'b0, v1};
        o_res0.last = (o_cnt == 2'd1);
        o_res1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_ts   <= '0;
            r_pos  <= '0;
        end else if (i_adv) begin
            r_mode <= n_mode;
            r_ts   <= n_ts;
            r_pos  <= n_pos;
        end
    end

endmodule

// File: rtl/core/llex_fifo.sv
// small result queue taking up to two results per cycle
`timescale 1ns / 1ps

module llex_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_push_cnt,
    input  llex_pkg::t_res     i_res0,
    input  llex_pkg::t_res     i_res1,
    input  logic               i_pop,
    output llex_pkg::t_res     o_head,
    output logic               o_nonempty,
    output logic               o_room2
);
    import llex_pkg::*;

    t_res               r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wp, n_wp;
    logic [QPTR_W-1:0]  r_rp, n_rp;
    logic [QPTR_W:0]    r_count, n_count;
    logic               pop_ok;

    assign o_head     = r_mem[r_rp];
    assign o_nonempty = (r_count != '0);
    assign o_room2    = (r_count <= (QPTR_W+1)'(QDEPTH - 2));
    assign pop_ok     = i_pop && o_nonempty;

    always_comb begin
        n_wp    = r_wp + QPTR_W'(i_push_cnt);
        n_rp    = r_rp + QPTR_W'(pop_ok);
        n_count = r_count + (QPTR_W+1)'(i_push_cnt) - (QPTR_W+1)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) r_mem[r_wp] <= i_res0;
        if (i_push_cnt == 2'd2) r_mem[r_wp + QPTR_W'(1)] <= i_res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/core/lisp_token_lexer_unit.sv
// top level of the streaming lisp token lexer
`timescale 1ns / 1ps

// pipeline: a character is registered at its transfer, decoded from that register once
// the four-entry result queue has room for two results, and its tokens are queued there
// throughput: one character per cycle while the queue has room for two results; a
// character that yields two tokens pushes both into the queue together
// reset: synchronous active low, clears position, token start and lexer mode

module lisp_token_lexer_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_ch,
    output logic                  o_stall,
    output logic                  o_valid,
    output logic [3:0]            o_kind,
    output logic [15:0]           o_start_res,
    output logic [15:0]           o_stop,
    output logic                  o_last,
    input  logic                  i_stall
);
    import llex_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       adv;
    logic       room2;
    logic       accept;
    t_res       res0, res1, head;
    logic [1:0] cnt;
    logic [1:0] push_cnt;

    assign adv      = r_in_valid && room2;
    assign o_stall  = r_in_valid && !room2;
    assign accept   = i_valid && !o_stall;
    assign push_cnt = adv ? cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_ch <= i_ch;
    end

    llex_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ch    (r_ch),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_cnt   (cnt)
    );

    llex_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (res0),
        .i_res1     (res1),
        .i_pop      (!i_stall),
        .o_head     (head),
        .o_nonempty (o_valid),
        .o_room2    (room2)
    );

    assign o_kind      = head.kind;
    assign o_start_res = head.start_res;
    assign o_stop      = head.stop;
    assign o_last      = head.last;

endmodule
